// ===== rtl/sscc_pkg.sv =====
// Shared types and constants for the segmented stream capture controller.
// Used by sscc_core and segmented_stream_capture_ctrl; depends on nothing.
`default_nettype none

package sscc_pkg;

   // Ring geometry
   localparam int SEG_WORDS   = 1024;
   localparam int NUM_SEGS    = 6;
   localparam int TOTAL_WORDS = SEG_WORDS * NUM_SEGS;

   // Fixed field widths
   localparam int ADDR_W  = 13;
   localparam int DATA_W  = 16;
   localparam int SEG_W   = 3;
   localparam int TICK_W  = 4;
   localparam int PHASE_W = 2;

   // Segment count width, wide enough to hold NUM_SEGS and NUM_SEGS + 1
   localparam int SEGN_W = $clog2(NUM_SEGS + 2);

   localparam logic [TICK_W-1:0] TICK_MAX          = 4'd15;
   localparam logic [TICK_W-1:0] LONG_PRESS_RESET  = 4'd3;

   // Item kinds
   typedef enum logic [1:0] {
      OP_SPI_WORD = 2'd0,
      OP_WAKE     = 2'd1,
      OP_KEY      = 2'd2,
      OP_TICK     = 2'd3
   } op_type;

   // Capture phases
   localparam logic [PHASE_W-1:0] PHASE_IDLE       = 2'd0;
   localparam logic [PHASE_W-1:0] PHASE_WAKE_START = 2'd1;
   localparam logic [PHASE_W-1:0] PHASE_WAKE_END   = 2'd2;
   localparam logic [PHASE_W-1:0] PHASE_KEY_START  = 2'd3;

   // One input word
   typedef struct packed {
      logic [1:0]       op;
      logic [7:0]       byte_first;
      logic [7:0]       byte_second;
      logic             pin_level;
      logic [SEG_W-1:0] play_segment;
   } item_type;

   // One result word
   typedef struct packed {
      logic               write_valid;
      logic [ADDR_W-1:0]  write_addr;
      logic [DATA_W-1:0]  write_data;
      logic [SEG_W-1:0]   segment_done;
      logic               hold_request;
      logic               capture_on;
      logic [PHASE_W-1:0] capture_phase;
      logic               reset_request;
      logic               stray_word;
   } result_type;

endpackage

`default_nettype wire

// ===== rtl/sscc_core.sv =====
// Capture state and per-word update logic: ring index, wake and key edge
// tracking, hold tick counter. Depends on sscc_pkg.
`default_nettype none

module sscc_core (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        step,
   input  wire sscc_pkg::item_type          item,
   input  wire logic [sscc_pkg::TICK_W-1:0] long_press_ticks,
   output sscc_pkg::result_type             result
);

   logic [sscc_pkg::ADDR_W-1:0]  word_index_ff, word_index_in;
   logic                         capture_sel_ff, capture_sel_in;
   logic [sscc_pkg::PHASE_W-1:0] phase_ff, phase_in;
   logic [sscc_pkg::SEG_W-1:0]   last_filled_ff, last_filled_in;
   logic                         stray_flag_ff, stray_flag_in;
   logic [sscc_pkg::TICK_W-1:0]  hold_ticks_ff, hold_ticks_in;
   logic                         tick_enable_ff, tick_enable_in;
   logic                         key_expect_high_ff, key_expect_high_in;
   logic                         wake_expect_high_ff, wake_expect_high_in;
   logic                         spi_accept_ff, spi_accept_in;

   logic [sscc_pkg::ADDR_W:0]    index_inc;
   logic [sscc_pkg::SEGN_W-1:0]  seg_num;
   logic [sscc_pkg::SEGN_W-1:0]  seg_after;
   logic                         seg_full;
   logic [sscc_pkg::TICK_W-1:0]  tick_inc;

   // Segment bookkeeping for the word at the head of the ring
   assign index_inc = {1'b0, word_index_ff} + 1'b1;
   assign seg_full  = (index_inc % sscc_pkg::SEG_WORDS) == '0;
   assign seg_num   = sscc_pkg::SEGN_W'(index_inc / sscc_pkg::SEG_WORDS);
   assign seg_after = (seg_num == sscc_pkg::SEGN_W'(sscc_pkg::NUM_SEGS)) ?
                      sscc_pkg::SEGN_W'(1) : seg_num + 1'b1;
   assign tick_inc  = hold_ticks_ff + 1'b1;

   // Next state and result for the current word
   always_comb begin
      word_index_in       = word_index_ff;
      capture_sel_in      = capture_sel_ff;
      phase_in            = phase_ff;
      last_filled_in      = last_filled_ff;
      stray_flag_in       = stray_flag_ff;
      hold_ticks_in       = hold_ticks_ff;
      tick_enable_in      = tick_enable_ff;
      key_expect_high_in  = key_expect_high_ff;
      wake_expect_high_in = wake_expect_high_ff;
      spi_accept_in       = spi_accept_ff;

      result = '0;

      case (sscc_pkg::op_type'(item.op))
         sscc_pkg::OP_SPI_WORD: begin
            if (spi_accept_ff) begin
               if (capture_sel_ff) begin
                  if (32'(word_index_ff) < sscc_pkg::TOTAL_WORDS) begin
                     result.write_valid = 1'b1;
                     result.write_addr  = word_index_ff;
                     result.write_data  = {item.byte_first, item.byte_second};
                     word_index_in      = index_inc[sscc_pkg::ADDR_W-1:0];
                     if (seg_full) begin
                        last_filled_in      = sscc_pkg::SEG_W'(seg_num);
                        result.segment_done = sscc_pkg::SEG_W'(seg_num);
                        result.hold_request =
                           (sscc_pkg::SEGN_W'(item.play_segment) == seg_after);
                        if (seg_num == sscc_pkg::SEGN_W'(sscc_pkg::NUM_SEGS)) begin
                           word_index_in = '0;
                        end
                     end
                  end
               end else begin
                  stray_flag_in = 1'b1;
               end
            end
         end
         sscc_pkg::OP_WAKE: begin
            if (wake_expect_high_ff && item.pin_level) begin
               wake_expect_high_in = 1'b0;
               last_filled_in      = '0;
               phase_in            = sscc_pkg::PHASE_WAKE_START;
               capture_sel_in      = 1'b1;
               word_index_in       = '0;
               spi_accept_in       = 1'b1;
            end else if (!wake_expect_high_ff && !item.pin_level) begin
               wake_expect_high_in = 1'b1;
               phase_in            = sscc_pkg::PHASE_WAKE_END;
               spi_accept_in       = 1'b0;
            end
         end
         sscc_pkg::OP_KEY: begin
            if (!key_expect_high_ff && !item.pin_level) begin
               key_expect_high_in = 1'b1;
               tick_enable_in     = 1'b1;
               hold_ticks_in      = '0;
               if (!capture_sel_ff) begin
                  capture_sel_in = 1'b1;
                  phase_in       = sscc_pkg::PHASE_KEY_START;
               end
            end else if (key_expect_high_ff && item.pin_level) begin
               key_expect_high_in = 1'b0;
               // Short press cancels a key-started capture
               if ((hold_ticks_ff < long_press_ticks) &&
                   (phase_ff == sscc_pkg::PHASE_KEY_START)) begin
                  capture_sel_in = 1'b0;
                  phase_in       = sscc_pkg::PHASE_IDLE;
               end
               tick_enable_in = 1'b0;
            end
         end
         sscc_pkg::OP_TICK: begin
            if (tick_enable_ff && (hold_ticks_ff < sscc_pkg::TICK_MAX)) begin
               hold_ticks_in = tick_inc;
               if (tick_inc == long_press_ticks) begin
                  result.reset_request = 1'b1;
                  spi_accept_in        = 1'b0;
               end
            end
         end
         default: begin
         end
      endcase

      result.capture_on    = capture_sel_in;
      result.capture_phase = phase_in;
      result.stray_word    = stray_flag_in;
   end

   // Hold state; advance only on a word that moves to the result stage
   always_ff @(posedge clock) begin
      if (reset) begin
         word_index_ff       <= '0;
         capture_sel_ff      <= 1'b0;
         phase_ff            <= sscc_pkg::PHASE_IDLE;
         last_filled_ff      <= '0;
         stray_flag_ff       <= 1'b0;
         hold_ticks_ff       <= '0;
         tick_enable_ff      <= 1'b0;
         key_expect_high_ff  <= 1'b0;
         wake_expect_high_ff <= 1'b1;
         spi_accept_ff       <= 1'b1;
      end else if (step) begin
         word_index_ff       <= word_index_in;
         capture_sel_ff      <= capture_sel_in;
         phase_ff            <= phase_in;
         last_filled_ff      <= last_filled_in;
         stray_flag_ff       <= stray_flag_in;
         hold_ticks_ff       <= hold_ticks_in;
         tick_enable_ff      <= tick_enable_in;
         key_expect_high_ff  <= key_expect_high_in;
         wake_expect_high_ff <= wake_expect_high_in;
         spi_accept_ff       <= spi_accept_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/segmented_stream_capture_ctrl.sv =====
// Top level of the segmented stream capture controller: input register,
// result register, handshakes and the long press register. Uses sscc_pkg
// and sscc_core.
//
// Usage:
//   req_*  : one word per event (SPI byte pair, wake edge, key edge, tick).
//   rsp_*  : exactly one result word per request word, in order.
//   csr_*  : write of long_press_ticks (4 bits); csr_ready is always high.
//            Write only while no request word is in flight.
// Path: a request word accepted into the input register is processed by
//   the core logic, captured in the result register and presented on rsp_*.
// Throughput: one word per cycle while rsp_ready is high; the input
//   register and the result register each hold one word, and the core
//   state updates as a word moves from the first into the second.
// Stall: when rsp_ready is low the result holds and the input register
//   still takes one more word; req_ready drops once both are full.
// Reset: synchronous, active high; empties both registers, sets the
//   capture state to idle (wake expects a rising edge, key a falling
//   edge, SPI words accepted) and long_press_ticks to 3.
`default_nettype none

module segmented_stream_capture_ctrl (
   input  wire logic        clock,
   input  wire logic        reset,

   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [1:0]  req_op,
   input  wire logic [7:0]  req_byte_first,
   input  wire logic [7:0]  req_byte_second,
   input  wire logic        req_pin_level,
   input  wire logic [2:0]  req_play_segment,

   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic             rsp_write_valid,
   output logic [12:0]      rsp_write_addr,
   output logic [15:0]      rsp_write_data,
   output logic [2:0]       rsp_segment_done,
   output logic             rsp_hold_request,
   output logic             rsp_capture_on,
   output logic [1:0]       rsp_capture_phase,
   output logic             rsp_reset_request,
   output logic             rsp_stray_word,

   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [3:0]  csr_long_press_ticks
);

   logic                              in_valid_ff;
   sscc_pkg::item_type                item_ff;
   logic                              out_valid_ff;
   sscc_pkg::result_type              result_ff;
   logic [sscc_pkg::TICK_W-1:0]       long_press_ff;
   sscc_pkg::result_type              result_in;
   logic                              advance;

   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign csr_ready = 1'b1;

   // Long press threshold register
   always_ff @(posedge clock) begin
      if (reset) begin
         long_press_ff <= sscc_pkg::LONG_PRESS_RESET;
      end else if (csr_valid) begin
         long_press_ff <= csr_long_press_ticks;
      end
   end

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         item_ff.op           <= req_op;
         item_ff.byte_first   <= req_byte_first;
         item_ff.byte_second  <= req_byte_second;
         item_ff.pin_level    <= req_pin_level;
         item_ff.play_segment <= req_play_segment;
      end
   end

   sscc_core u_core (
      .clock            (clock),
      .reset            (reset),
      .step             (advance),
      .item             (item_ff),
      .long_press_ticks (long_press_ff),
      .result           (result_in)
   );

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         result_ff <= result_in;
      end
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_write_valid   = result_ff.write_valid;
   assign rsp_write_addr    = result_ff.write_addr;
   assign rsp_write_data    = result_ff.write_data;
   assign rsp_segment_done  = result_ff.segment_done;
   assign rsp_hold_request  = result_ff.hold_request;
   assign rsp_capture_on    = result_ff.capture_on;
   assign rsp_capture_phase = result_ff.capture_phase;
   assign rsp_reset_request = result_ff.reset_request;
   assign rsp_stray_word    = result_ff.stray_word;

endmodule

`default_nettype wire
